/* rtl/lrukv_pkg.sv */
`timescale 1ns / 1ps

package lrukv_pkg;

  // Store geometry.
  localparam int MaxEntries = 16;
  localparam int IdxW       = $clog2(MaxEntries);
  localparam int RankW      = IdxW;
  localparam int OccW       = $clog2(MaxEntries + 1);

  // Field widths.
  localparam int KeyW = 32;
  localparam int ValW = 32;

  // Configuration port.
  localparam int PaddrW  = 3;
  localparam int PdataW  = 32;
  localparam int CapW    = 5;
  localparam int CapReset = 16;

  // Register addresses.
  localparam logic [PaddrW-1:0] AddrCapacity = PaddrW'(0);

  // Operation codes.
  localparam logic FuncGet = 1'b0;
  localparam logic FuncPut = 1'b1;

  // Value reported on a miss and on every put.
  localparam logic signed [ValW-1:0] MissValue = '1;

  // One request.
  typedef struct packed {
    logic                   func;
    logic signed [KeyW-1:0] key;
    logic signed [ValW-1:0] value;
  } in_item_t;

  // One result.
  typedef struct packed {
    logic                   found;
    logic signed [ValW-1:0] read_value;
    logic                   evicted;
    logic signed [KeyW-1:0] evicted_key;
  } out_item_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StUpdate,
    StDone
  } state_e;

endpackage

/* rtl/lrukv_cfg_regs.sv */
`timescale 1ns / 1ps

module lrukv_cfg_regs (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lrukv_pkg::PaddrW-1:0]     paddr,
  input  logic [lrukv_pkg::PdataW-1:0]     pwdata,
  output logic [lrukv_pkg::PdataW-1:0]     prdata,
  output logic                             pready,
  output logic [lrukv_pkg::OccW-1:0]       cap_eff_o
);

  logic [lrukv_pkg::CapW-1:0] cap_q;
  logic [lrukv_pkg::CapW-1:0] cap_d;
  logic                       wr_en;

  // The port never inserts wait states.
  assign pready = 1'b1;

  // A write completes in the access phase.
  assign wr_en = psel && penable && pwrite && pready;

  always_comb begin
    cap_d = cap_q;
    if (wr_en && (paddr == lrukv_pkg::AddrCapacity)) begin
      cap_d = pwdata[lrukv_pkg::CapW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lrukv_pkg::CapW'(lrukv_pkg::CapReset);
    end else begin
      cap_q <= cap_d;
    end
  end

  // Read back the raw register value.
  always_comb begin
    prdata = '0;
    if (paddr == lrukv_pkg::AddrCapacity) begin
      prdata = {{(lrukv_pkg::PdataW - lrukv_pkg::CapW){1'b0}}, cap_q};
    end
  end

  // Clamp the capacity to the range the store supports.
  always_comb begin
    if (cap_q == '0) begin
      cap_eff_o = lrukv_pkg::OccW'(1);
    end else if (lrukv_pkg::OccW'(cap_q) > lrukv_pkg::OccW'(lrukv_pkg::MaxEntries)) begin
      cap_eff_o = lrukv_pkg::OccW'(lrukv_pkg::MaxEntries);
    end else begin
      cap_eff_o = lrukv_pkg::OccW'(cap_q);
    end
  end

endmodule

/* rtl/lru_key_value_cache.sv */
`timescale 1ns / 1ps

// Fully associative key-value cache of 16 entries with least-recently-used
// replacement. A get returns the stored value on a hit and -1 on a miss; a
// put updates a present key or inserts a new entry, evicting the least recent
// one once the occupancy reaches the capacity register. Recency is kept as a
// rank per entry (0 is most recent). One key comparator and one rank unit are
// stepped over the entries one per cycle: a lookup pass visits entries until
// a hit or through all 16, then a rank update pass over every entry follows
// for every hit and every inserting put, and then the result register is
// loaded. The result load waits while the result register still holds a
// result that has not been taken, and the sequencer returns to idle before
// the next request can be taken. in_stall_o is high from the transfer until
// the sequencer is idle again. The result register lets the next request be
// taken while a result still waits on a stalled output. The capacity
// register sits at byte address 0; write it only while the block is idle.
// The store is empty after reset.

module lru_key_value_cache (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Request channel.
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  lrukv_pkg::in_item_t              in_data_i,
  // Result channel.
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output lrukv_pkg::out_item_t             out_data_o,
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [lrukv_pkg::PaddrW-1:0]     paddr,
  input  logic [lrukv_pkg::PdataW-1:0]     pwdata,
  output logic [lrukv_pkg::PdataW-1:0]     prdata,
  output logic                             pready
);

  localparam int N     = lrukv_pkg::MaxEntries;
  localparam int IdxW  = lrukv_pkg::IdxW;
  localparam int RankW = lrukv_pkg::RankW;
  localparam int OccW  = lrukv_pkg::OccW;
  localparam int KeyW  = lrukv_pkg::KeyW;
  localparam int ValW  = lrukv_pkg::ValW;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(N - 1);

  logic [OccW-1:0] cap_eff;

  // Entry store.
  logic [N-1:0]           valid_q;
  logic [N-1:0]           valid_d;
  logic [KeyW-1:0]        key_mem  [N];
  logic [ValW-1:0]        val_mem  [N];
  logic [RankW-1:0]       rank_mem [N];

  // Sequencer and control state.
  lrukv_pkg::state_e      state_q, state_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [OccW-1:0]        occ_q, occ_d;
  logic                   hit_q, hit_d;
  logic                   age_q, age_d;
  logic                   ev_q, ev_d;
  logic                   lru_found_q, lru_found_d;
  logic                   free_found_q, free_found_d;
  logic                   out_valid_q, out_valid_d;

  // Per-request working registers.
  lrukv_pkg::in_item_t    op_q, op_d;
  lrukv_pkg::out_item_t   out_q, out_d;
  logic [IdxW-1:0]        target_q, target_d;
  logic [RankW-1:0]       hit_rank_q, hit_rank_d;
  logic [ValW-1:0]        hit_val_q, hit_val_d;
  logic [IdxW-1:0]        lru_idx_q, lru_idx_d;
  logic [RankW-1:0]       lru_rank_q, lru_rank_d;
  logic [KeyW-1:0]        lru_key_q, lru_key_d;
  logic [IdxW-1:0]        free_idx_q, free_idx_d;
  logic [KeyW-1:0]        ev_key_q, ev_key_d;

  // Entry read at the sequencer index.
  logic                   cur_valid;
  logic [KeyW-1:0]        cur_key;
  logic [RankW-1:0]       cur_rank;
  logic [ValW-1:0]        cur_val;
  logic                   key_match;
  logic                   lru_take;

  // Entry write controls for the update pass.
  logic                   wr_slot;
  logic                   wr_kv;
  logic                   wr_bump;

  logic                   in_xfer;
  logic                   out_xfer;

  lrukv_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .cap_eff_o (cap_eff)
  );

  assign in_stall_o  = (state_q != lrukv_pkg::StIdle);
  assign in_xfer     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_xfer    = out_valid_q && !out_stall_i;

  // Shared key comparator and rank compare at the current index.
  assign cur_valid = valid_q[idx_q];
  assign cur_key   = key_mem[idx_q];
  assign cur_rank  = rank_mem[idx_q];
  assign cur_val   = val_mem[idx_q];
  assign key_match = cur_valid && (cur_key == op_q.key);
  assign lru_take  = cur_valid && (!lru_found_q || (cur_rank >= lru_rank_q));

  // Sequencer: next state, control and working registers.
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    occ_d        = occ_q;
    hit_d        = hit_q;
    age_d        = age_q;
    ev_d         = ev_q;
    lru_found_d  = lru_found_q;
    free_found_d = free_found_q;
    op_d         = op_q;
    target_d     = target_q;
    hit_rank_d   = hit_rank_q;
    hit_val_d    = hit_val_q;
    lru_idx_d    = lru_idx_q;
    lru_rank_d   = lru_rank_q;
    lru_key_d    = lru_key_q;
    free_idx_d   = free_idx_q;
    ev_key_d     = ev_key_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_xfer;
    valid_d      = valid_q;
    wr_slot      = 1'b0;
    wr_kv        = 1'b0;
    wr_bump      = 1'b0;

    unique case (state_q)
      lrukv_pkg::StIdle: begin
        if (in_xfer) begin
          op_d         = in_data_i;
          idx_d        = '0;
          hit_d        = 1'b0;
          age_d        = 1'b0;
          ev_d         = 1'b0;
          ev_key_d     = '0;
          lru_found_d  = 1'b0;
          free_found_d = 1'b0;
          state_d      = lrukv_pkg::StScan;
        end
      end

      lrukv_pkg::StScan: begin
        if (key_match) begin
          // Hit: promote this entry in the update pass.
          hit_d      = 1'b1;
          target_d   = idx_q;
          hit_rank_d = cur_rank;
          hit_val_d  = cur_val;
          idx_d      = '0;
          state_d    = lrukv_pkg::StUpdate;
        end else begin
          // Track the least recent valid entry (last one wins on a tie).
          if (lru_take) begin
            lru_found_d = 1'b1;
            lru_idx_d   = idx_q;
            lru_rank_d  = cur_rank;
            lru_key_d   = cur_key;
          end
          // Track the first free slot.
          if (!cur_valid && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = idx_q;
          end
          if (idx_q == LastIdx) begin
            idx_d = '0;
            if (op_q.func == lrukv_pkg::FuncGet) begin
              state_d = lrukv_pkg::StDone;
            end else if (occ_q >= cap_eff) begin
              // Full: replace the least recent entry.
              ev_d     = 1'b1;
              ev_key_d = lru_key_d;
              target_d = lru_idx_d;
              age_d    = 1'b1;
              state_d  = lrukv_pkg::StUpdate;
            end else begin
              target_d = free_idx_d;
              age_d    = 1'b1;
              occ_d    = occ_q + OccW'(1);
              state_d  = lrukv_pkg::StUpdate;
            end
          end else begin
            idx_d = idx_q + IdxW'(1);
          end
        end
      end

      lrukv_pkg::StUpdate: begin
        if (idx_q == target_q) begin
          // The touched entry becomes most recent.
          valid_d[idx_q] = 1'b1;
          wr_slot        = 1'b1;
          wr_kv          = !hit_q || (op_q.func == lrukv_pkg::FuncPut);
        end else if (cur_valid && (age_q || (cur_rank < hit_rank_q))) begin
          wr_bump = 1'b1;
        end
        if (idx_q == LastIdx) begin
          idx_d   = '0;
          state_d = lrukv_pkg::StDone;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end

      lrukv_pkg::StDone: begin
        // Load the result once the result register is free.
        if (!out_valid_q || out_xfer) begin
          out_d.found       = hit_q;
          out_d.read_value  = (hit_q && (op_q.func == lrukv_pkg::FuncGet)) ?
                              hit_val_q : lrukv_pkg::MissValue;
          out_d.evicted     = ev_q;
          out_d.evicted_key = ev_key_q;
          out_valid_d       = 1'b1;
          state_d           = lrukv_pkg::StIdle;
        end
      end

      default: begin
        state_d = lrukv_pkg::StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lrukv_pkg::StIdle;
      idx_q        <= '0;
      occ_q        <= '0;
      hit_q        <= 1'b0;
      age_q        <= 1'b0;
      ev_q         <= 1'b0;
      lru_found_q  <= 1'b0;
      free_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
      valid_q      <= '0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      occ_q        <= occ_d;
      hit_q        <= hit_d;
      age_q        <= age_d;
      ev_q         <= ev_d;
      lru_found_q  <= lru_found_d;
      free_found_q <= free_found_d;
      out_valid_q  <= out_valid_d;
      valid_q      <= valid_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    out_q      <= out_d;
    target_q   <= target_d;
    hit_rank_q <= hit_rank_d;
    hit_val_q  <= hit_val_d;
    lru_idx_q  <= lru_idx_d;
    lru_rank_q <= lru_rank_d;
    lru_key_q  <= lru_key_d;
    free_idx_q <= free_idx_d;
    ev_key_q   <= ev_key_d;
  end

  // Entry arrays, written at the sequencer index only.
  always_ff @(posedge clk_i) begin
    if (wr_slot) begin
      rank_mem[idx_q] <= '0;
    end else if (wr_bump) begin
      rank_mem[idx_q] <= cur_rank + RankW'(1);
    end
    if (wr_slot && wr_kv) begin
      val_mem[idx_q] <= op_q.value;
    end
    if (wr_slot && !hit_q) begin
      key_mem[idx_q] <= op_q.key;
    end
  end

endmodule
